>>> src/rsrc_pkg.sv
// Shared constants, types and tables for the ray segment range caster.
package rsrc_pkg;

    localparam int MAX_SEGMENTS_DEF = 8;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_GAIN = 9949;
    localparam int Q14_ONE = 16384;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST = 1'b1;

    localparam logic [1:0] REG_RANGE_MIN = 2'd0;
    localparam logic [1:0] REG_RANGE_MAX = 2'd1;
    localparam logic [1:0] REG_SEG_COUNT = 2'd2;

    localparam logic [14:0] RANGE_MIN_RST = 15'd51;
    localparam logic [14:0] RANGE_MAX_RST = 15'd5120;

    typedef struct packed {
        logic        opcode;
        logic [2:0]  entry_index;
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
        logic [15:0] beam_angle;
    } cast_in_t;

    typedef struct packed {
        logic [14:0] hit_distance;
        logic        hit_found;
    } cast_out_t;

    // One beam as it travels down the cell chain.
    typedef struct packed {
        logic               valid;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic signed [15:0] c;
        logic signed [15:0] s;
        logic [14:0]        best;
        logic               found;
    } beam_t;

    function automatic logic [15:0] atan_step(input logic [3:0] i);
        logic [15:0] r;
        case (i)
            4'd0: r = 16'd8192;
            4'd1: r = 16'd4836;
            4'd2: r = 16'd2555;
            4'd3: r = 16'd1297;
            4'd4: r = 16'd651;
            4'd5: r = 16'd326;
            4'd6: r = 16'd163;
            4'd7: r = 16'd81;
            4'd8: r = 16'd41;
            4'd9: r = 16'd20;
            4'd10: r = 16'd10;
            4'd11: r = 16'd5;
            4'd12: r = 16'd3;
            4'd13: r = 16'd1;
            4'd14: r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

>>> src/rsrc_if.sv
// Valid/ready stream interface used by both channels.
interface rsrc_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/ray_segment_range_caster_top.sv
// Top level of the ray segment range caster.
//
//  channel | dir | payload                                          | accepted when
//  --------+-----+--------------------------------------------------+--------------
//  in_ch   | in  | opcode, entry_index, first/second x/y, beam_angle | valid && ready
//  out_ch  | out | hit_distance, hit_found                          | valid && ready
//  cfg     | in  | cfg_we, cfg_index, cfg_data                      | cfg_we
//
// A segment write takes one beat. A cast starts a 16-step CORDIC that hands the beam to
// the first cell through its done register. A cell in use passes the beam through capture,
// products, a restoring divide and compare; a cell not in use passes it on unchanged.
// The result register loads when the beam leaves the last cell, and the next beat can be
// taken once that result has been accepted. Reset clears control state and loads the
// register reset values; segment storage is undefined until written. The input is held
// off while a cast is in flight or a result waits in the output register, so a stalled
// receiver only stretches that wait.
module ray_segment_range_caster_top #(
    parameter int MAX_SEGMENTS = rsrc_pkg::MAX_SEGMENTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    rsrc_if.sink        in_ch,
    rsrc_if.source      out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    rsrc_pkg::cast_in_t  in_w;
    rsrc_pkg::beam_t     chain_w [MAX_SEGMENTS + 1];

    logic [14:0] near_limit_reg, far_limit_reg;
    logic [3:0]  seg_count_reg;
    logic        busy_reg;
    logic        out_valid_reg;
    rsrc_pkg::cast_out_t out_reg;
    logic [15:0] org_x_reg, org_y_reg;
    logic        cordic_done;
    logic signed [15:0] cos_w, sin_w;
    logic [CW-1:0] n_used;
    logic        accept_w;

    assign in_w = in_ch.data;
    // Idle only once the last result has gone out.
    assign in_ch.ready = !busy_reg && !out_valid_reg;

    assign accept_w = in_ch.valid && in_ch.ready;

    // A count above the table size uses the whole table.
    assign n_used = (32'(seg_count_reg) > MAX_SEGMENTS) ? CW'(MAX_SEGMENTS)
                                                        : CW'(seg_count_reg);

    rsrc_cordic u_cordic (
        .clk(clk), .rst_n(rst_n),
        .start(accept_w && in_w.opcode == rsrc_pkg::OP_CAST),
        .angle(in_w.beam_angle), .done(cordic_done),
        .cos_q(cos_w), .sin_q(sin_w)
    );

    always_comb
    begin
        chain_w[0].valid = cordic_done;
        chain_w[0].ox = org_x_reg;
        chain_w[0].oy = org_y_reg;
        chain_w[0].c = cos_w;
        chain_w[0].s = sin_w;
        chain_w[0].best = far_limit_reg;
        chain_w[0].found = 1'b0;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++)
        begin : g_cell
            rsrc_cell u_cell (
                .clk(clk), .rst_n(rst_n),
                .wr_en(accept_w && in_w.opcode == rsrc_pkg::OP_WRITE
                       && 32'(in_w.entry_index) == g),
                .wr_seg({in_w.second_y, in_w.second_x, in_w.first_y, in_w.first_x}),
                .in_use(32'(n_used) > g),
                .near_limit(near_limit_reg),
                .beam_in(chain_w[g]),
                .beam_out(chain_w[g + 1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_limit_reg <= rsrc_pkg::RANGE_MIN_RST;
            far_limit_reg <= rsrc_pkg::RANGE_MAX_RST;
            seg_count_reg <= '0;
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rsrc_pkg::REG_RANGE_MIN: near_limit_reg <= cfg_data;
                    rsrc_pkg::REG_RANGE_MAX: far_limit_reg <= cfg_data;
                    rsrc_pkg::REG_SEG_COUNT: seg_count_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (accept_w && in_w.opcode == rsrc_pkg::OP_CAST)
            begin
                busy_reg <= 1'b1;
                org_x_reg <= in_w.first_x;
                org_y_reg <= in_w.first_y;
            end
            if (chain_w[MAX_SEGMENTS].valid)
            begin
                busy_reg <= 1'b0;
                out_valid_reg <= 1'b1;
                out_reg.hit_distance <= chain_w[MAX_SEGMENTS].best;
                out_reg.hit_found <= chain_w[MAX_SEGMENTS].found;
            end
            else if (out_ch.valid && out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !in_ch.ready) else $error("input taken during cast");
    a_result_ends_cast: assert property (@(posedge clk) disable iff (!rst_n)
        chain_w[MAX_SEGMENTS].valid |=> !busy_reg && out_valid_reg)
        else $error("result did not close cast");
    a_found_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.hit_found |-> out_reg.hit_distance < far_limit_reg)
        else $error("hit at or beyond the maximum range");

endmodule

>>> src/rsrc_cordic.sv
// Iterative CORDIC: one rotation step per cycle, gives Q14 cosine and sine.
module rsrc_cordic
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [15:0]        angle,
    output logic               done,
    output logic signed [15:0] cos_q,
    output logic signed [15:0] sin_q
);

    logic signed [18:0] x_reg, y_reg, z_reg;
    logic               flip_reg;
    logic [3:0]         step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [15:0] cos_reg, sin_reg;

    logic signed [18:0] z0, xs, ys, xn, yn, zn, at, xf, yf;

    always_comb
    begin
        z0 = 19'(signed'(angle));
        at = 19'(rsrc_pkg::atan_step(step_reg));
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        if (!z_reg[18])
        begin
            xn = x_reg - ys;
            yn = y_reg + xs;
            zn = z_reg - at;
        end
        else
        begin
            xn = x_reg + ys;
            yn = y_reg - xs;
            zn = z_reg + at;
        end
        xf = flip_reg ? -xn : xn;
        yf = flip_reg ? -yn : yn;
    end

    function automatic logic signed [15:0] clamp(input logic signed [18:0] v);
        if (v > 19'sd16384)
            return 16'sd16384;
        else if (v < -19'sd16384)
            return -16'sd16384;
        else
            return v[15:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (start)
            begin
                done_reg <= 1'b0;
                busy_reg <= 1'b1;
                step_reg <= '0;
                x_reg <= 19'(rsrc_pkg::CORDIC_GAIN);
                y_reg <= '0;
                if (z0 > 19'sd16384)
                begin
                    z_reg <= z0 - 19'sd32768;
                    flip_reg <= 1'b1;
                end
                else if (z0 < -19'sd16384)
                begin
                    z_reg <= z0 + 19'sd32768;
                    flip_reg <= 1'b1;
                end
                else
                begin
                    z_reg <= z0;
                    flip_reg <= 1'b0;
                end
            end
            else if (busy_reg)
            begin
                x_reg <= xn;
                y_reg <= yn;
                z_reg <= zn;
                step_reg <= step_reg + 4'd1;
                done_reg <= (step_reg == 4'(rsrc_pkg::CORDIC_STEPS - 1));
                if (step_reg == 4'(rsrc_pkg::CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    cos_reg <= clamp(xf);
                    sin_reg <= clamp(yf);
                end
            end
            else
                done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

>>> src/rsrc_cell.sv
// One chain cell: holds a segment, tests the passing beam against it.
module rsrc_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [63:0]        wr_seg,
    input  logic               in_use,
    input  logic [14:0]        near_limit,
    input  rsrc_pkg::beam_t    beam_in,
    output rsrc_pkg::beam_t    beam_out
);

    // Sub-steps: products, then a restoring divide, then compare.
    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_t;

    state_t             state_reg;
    logic [63:0]        seg_reg;
    rsrc_pkg::beam_t    hold_reg;
    rsrc_pkg::beam_t    out_reg;
    logic signed [34:0] den_reg, tn_reg, un_reg;
    logic               hit_reg;
    logic [48:0]        rem_reg;
    logic [48:0]        quo_reg;
    logic [5:0]         cnt_reg;
    logic [33:0]        dmag_reg;

    logic signed [16:0] sx, sy, qx, qy;
    logic signed [34:0] den_n, tn_n, un_n, den_a, tn_a, un_a;
    logic [49:0]        trial;
    logic               hit_ok;
    rsrc_pkg::beam_t    done_beam;

    always_comb
    begin
        sx = 17'(signed'(seg_reg[47:32])) - 17'(signed'(seg_reg[15:0]));
        sy = 17'(signed'(seg_reg[63:48])) - 17'(signed'(seg_reg[31:16]));
        qx = 17'(signed'(seg_reg[15:0])) - 17'(hold_reg.ox);
        qy = 17'(signed'(seg_reg[31:16])) - 17'(hold_reg.oy);
        den_n = 35'(hold_reg.c * sy) - 35'(hold_reg.s * sx);
        tn_n  = 35'(qx * sy) - 35'(qy * sx);
        un_n  = 35'(qx * hold_reg.s) - 35'(qy * hold_reg.c);
        den_a = den_reg[34] ? -den_reg : den_reg;
        tn_a  = den_reg[34] ? -tn_reg : tn_reg;
        un_a  = den_reg[34] ? -un_reg : un_reg;
        trial = {rem_reg, quo_reg[48]} - {16'd0, dmag_reg};
        hit_ok = hit_reg && quo_reg[48:15] == 34'd0
                 && quo_reg[14:0] >= near_limit
                 && quo_reg[14:0] < hold_reg.best;
        done_beam = hold_reg;
        if (hit_ok)
        begin
            done_beam.best = quo_reg[14:0];
            done_beam.found = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_reg.valid <= 1'b0;
            hold_reg.valid <= 1'b0;
        end
        else
        begin
            if (state_reg != S_DONE)
                out_reg.valid <= 1'b0;
            if (wr_en)
                seg_reg <= wr_seg;
            case (state_reg)
                S_IDLE:
                begin
                    if (beam_in.valid)
                    begin
                        hold_reg <= beam_in;
                        state_reg <= in_use ? S_MUL : S_DONE;
                        hit_reg <= 1'b0;
                    end
                end
                S_MUL:
                begin
                    den_reg <= den_n;
                    tn_reg <= tn_n;
                    un_reg <= un_n;
                    state_reg <= S_DIV;
                    cnt_reg <= '0;
                end
                S_DIV:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        hit_reg <= (den_reg != 0) && !tn_a[34] && !un_a[34]
                                   && (un_a <= den_a);
                        dmag_reg <= den_a[33:0];
                        rem_reg <= '0;
                        quo_reg <= {tn_a[33:0], 15'd0} >> 1;
                        cnt_reg <= 6'd1;
                    end
                    else
                    begin
                        if (!trial[49])
                        begin
                            rem_reg <= trial[48:0];
                            quo_reg <= {quo_reg[47:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[47:0], quo_reg[48]};
                            quo_reg <= {quo_reg[47:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg + 6'd1;
                        if (cnt_reg == 6'd49)
                            state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    out_reg <= done_beam;
                    hit_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign beam_out = out_reg;

endmodule

>>> bench/ray_segment_range_caster_top_tb.sv
// Self-checking bench for the ray segment range caster: directed table, then random beams.
`timescale 1ns / 100ps

module ray_segment_range_caster_top_tb;

    localparam int CAST_CYCLES = 18 + 53 * rsrc_pkg::MAX_SEGMENTS_DEF;
    localparam int CYCLE_LIMIT = 3_000_000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [14:0] cfg_data;

    rsrc_if #(.W($bits(rsrc_pkg::cast_in_t))) in_ch ();
    rsrc_if #(.W($bits(rsrc_pkg::cast_out_t))) out_ch ();

    ray_segment_range_caster_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Our own copy of the block's state, updated as beats are accepted and registers written.
    logic [14:0] min_range;
    logic [14:0] max_range;
    logic [3:0] used_entries;
    logic signed [15:0] wall_x1 [rsrc_pkg::MAX_SEGMENTS_DEF];
    logic signed [15:0] wall_y1 [rsrc_pkg::MAX_SEGMENTS_DEF];
    logic signed [15:0] wall_x2 [rsrc_pkg::MAX_SEGMENTS_DEF];
    logic signed [15:0] wall_y2 [rsrc_pkg::MAX_SEGMENTS_DEF];

    rsrc_pkg::cast_out_t pending_ranges [$];
    int mismatches;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;

    // While set, an accepted cast expects the typed-in result instead of the predictor's.
    bit use_fixed;
    rsrc_pkg::cast_out_t fixed_want;

    // A directed row carries an optional typed-in expectation.
    typedef struct {
        rsrc_pkg::cast_in_t beat;
        bit has_fixed;
        rsrc_pkg::cast_out_t fixed;
    } beam_row_t;

    beam_row_t directed_rows [$];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The run is cut off here once the cycle count passes CYCLE_LIMIT.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic signed [63:0] floor_asr(input logic signed [63:0] v,
                                                     input int sh);
        return v >>> sh;
    endfunction

    // Sine and cosine in Q14 from the 16-step integer rotation, folded by half a turn.
    function automatic void beam_direction(input logic [15:0] angle,
                                           output logic signed [63:0] c,
                                           output logic signed [63:0] s);
        logic signed [63:0] z, x, y, xs, ys;
        bit flip;
        z = $signed(angle);
        x = rsrc_pkg::CORDIC_GAIN;
        y = 0;
        flip = 0;
        if (z > 16384)
        begin
            z -= 32768;
            flip = 1;
        end
        else if (z < -16384)
        begin
            z += 32768;
            flip = 1;
        end
        for (int i = 0; i < rsrc_pkg::CORDIC_STEPS; i++)
        begin
            xs = floor_asr(x, i);
            ys = floor_asr(y, i);
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= rsrc_pkg::atan_step(i[3:0]);
            end
            else
            begin
                x += ys;
                y -= xs;
                z += rsrc_pkg::atan_step(i[3:0]);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = (x > rsrc_pkg::Q14_ONE) ? rsrc_pkg::Q14_ONE
          : (x < -rsrc_pkg::Q14_ONE) ? -rsrc_pkg::Q14_ONE : x;
        s = (y > rsrc_pkg::Q14_ONE) ? rsrc_pkg::Q14_ONE
          : (y < -rsrc_pkg::Q14_ONE) ? -rsrc_pkg::Q14_ONE : y;
    endfunction

    // Nearest accepted hit over the entries in use.
    function automatic rsrc_pkg::cast_out_t nearest_wall(input rsrc_pkg::cast_in_t b);
        rsrc_pkg::cast_out_t r;
        logic signed [63:0] c, s, sx, sy, qx, qy, den, tn, un;
        logic [63:0] d;
        int n;
        beam_direction(b.beam_angle, c, s);
        r.hit_distance = max_range;
        r.hit_found = 1'b0;
        n = (used_entries > rsrc_pkg::MAX_SEGMENTS_DEF) ? rsrc_pkg::MAX_SEGMENTS_DEF
                                                        : int'(used_entries);
        for (int k = 0; k < n; k++)
        begin
            sx = wall_x2[k] - wall_x1[k];
            sy = wall_y2[k] - wall_y1[k];
            qx = wall_x1[k] - b.first_x;
            qy = wall_y1[k] - b.first_y;
            den = c * sy - s * sx;
            tn = qx * sy - qy * sx;
            un = qx * s - qy * c;
            if (den == 0)
                continue;
            if (den < 0)
            begin
                den = -den;
                tn = -tn;
                un = -un;
            end
            if (tn < 0 || un < 0 || un > den)
                continue;
            d = (tn * rsrc_pkg::Q14_ONE) / den;
            if (d >= min_range && d < r.hit_distance)
            begin
                r.hit_distance = d[14:0];
                r.hit_found = 1'b1;
            end
        end
        return r;
    endfunction

    // Input side monitor: every accepted beat updates the table or queues a result.
    always @(posedge clk)
    begin
        rsrc_pkg::cast_in_t b;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            b = in_ch.data;
            if (b.opcode == rsrc_pkg::OP_WRITE)
            begin
                wall_x1[b.entry_index] = b.first_x;
                wall_y1[b.entry_index] = b.first_y;
                wall_x2[b.entry_index] = b.second_x;
                wall_y2[b.entry_index] = b.second_y;
            end
            else if (use_fixed)
                pending_ranges = {pending_ranges, fixed_want};
            else
                pending_ranges = {pending_ranges, nearest_wall(b)};
        end
    end

    // Output side: compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        rsrc_pkg::cast_out_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (pending_ranges.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: distance=%0d found=%0b",
                             got.hit_distance, got.hit_found);
            end
            else
            begin
                want = pending_ranges.pop_front();
                if (got.hit_distance !== want.hit_distance ||
                    got.hit_found !== want.hit_found)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("range mismatch: expected distance=%0d found=%0b, got distance=%0d found=%0b",
                                 want.hit_distance, want.hit_found,
                                 got.hit_distance, got.hit_found);
                end
            end
        end
    end

    // The receiver stalls at random according to the current phase.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Leaves valid high after the accepting edge so the next beat can follow directly.
    task automatic send_beat(input rsrc_pkg::cast_in_t b);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic release_in;
        in_ch.valid <= 1'b0;
    endtask

    // Wait until every cast has returned, then wait out CAST_CYCLES and a margin, since writes return nothing.
    task automatic drain;
        release_in();
        do
            @(posedge clk);
        while (pending_ranges.size() != 0);
        repeat (CAST_CYCLES + 20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            rsrc_pkg::REG_RANGE_MIN: min_range = val;
            rsrc_pkg::REG_RANGE_MAX: max_range = val;
            rsrc_pkg::REG_SEG_COUNT: used_entries = val[3:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // A row with a typed-in result waits for it before the next row goes out.
    task automatic send_row(input beam_row_t r);
        if (r.has_fixed || use_fixed)
        begin
            release_in();
            @(posedge clk);
            use_fixed = r.has_fixed;
            fixed_want = r.fixed;
        end
        send_beat(r.beat);
        if (r.has_fixed)
        begin
            release_in();
            do
                @(posedge clk);
            while (pending_ranges.size() != 0);
        end
    endtask

    function automatic rsrc_pkg::cast_in_t wall_beat(input logic [2:0] idx,
                                                     input int x1, input int y1,
                                                     input int x2, input int y2);
        rsrc_pkg::cast_in_t b;
        b = '0;
        b.opcode = rsrc_pkg::OP_WRITE;
        b.entry_index = idx;
        b.first_x = 16'(x1);
        b.first_y = 16'(y1);
        b.second_x = 16'(x2);
        b.second_y = 16'(y2);
        b.beam_angle = 16'($urandom);
        return b;
    endfunction

    function automatic rsrc_pkg::cast_in_t cast_beat(input int ox, input int oy,
                                                     input logic [15:0] ang);
        rsrc_pkg::cast_in_t b;
        b = '0;
        b.opcode = rsrc_pkg::OP_CAST;
        b.entry_index = 3'($urandom);
        b.first_x = 16'(ox);
        b.first_y = 16'(oy);
        b.second_x = 16'($urandom);
        b.second_y = 16'($urandom);
        b.beam_angle = ang;
        return b;
    endfunction

    function automatic void add_row(input rsrc_pkg::cast_in_t b, input bit fixed_ok,
                                    input int distance, input bit found);
        beam_row_t r;
        r.beat = b;
        r.has_fixed = fixed_ok;
        r.fixed.hit_distance = 15'(distance);
        r.fixed.hit_found = found;
        directed_rows = {directed_rows, r};
    endfunction

    task automatic run_rows;
        foreach (directed_rows[i])
            send_row(directed_rows[i]);
        drain();
        directed_rows.delete();
    endtask

    // Random coordinate: mostly near the origin so walls are reachable, sometimes full range.
    function automatic int rand_coord();
        if ($urandom_range(9) == 0)
            return $signed(16'($urandom));
        return $urandom_range(8000) - 4000;
    endfunction

    initial
    begin
        rsrc_pkg::cast_in_t b;
        int phase;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = rsrc_pkg::REG_RANGE_MIN;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        use_fixed = 1'b0;
        fixed_want = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        min_range = rsrc_pkg::RANGE_MIN_RST;
        max_range = rsrc_pkg::RANGE_MAX_RST;
        used_entries = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With no entries in use a cast must return the maximum range untouched.
        add_row(cast_beat(0, 0, 16'h0000), 1, rsrc_pkg::RANGE_MAX_RST, 0);
        add_row(cast_beat(-32768, 32767, 16'hFFFF), 1, rsrc_pkg::RANGE_MAX_RST, 0);
        run_rows();

        // Fill every entry: a wall ahead on each axis, a parallel wall, a
        // degenerate point and extreme coordinates.
        add_row(wall_beat(0, 2048, -1024, 2048, 1024), 0, 0, 0);
        add_row(wall_beat(1, -1024, 3072, 1024, 3072), 0, 0, 0);
        add_row(wall_beat(2, -3072, -1024, -3072, 1024), 0, 0, 0);
        add_row(wall_beat(3, 0, 0, 4096, 0), 0, 0, 0);
        add_row(wall_beat(4, 500, 500, 500, 500), 0, 0, 0);
        add_row(wall_beat(5, -32768, -32768, 32767, 32767), 0, 0, 0);
        add_row(wall_beat(6, 32767, -32768, -32768, 32767), 0, 0, 0);
        add_row(wall_beat(7, 1024, -4096, 1024, -2048), 0, 0, 0);
        run_rows();

        // Count above the table size is clamped to the table size.
        write_reg(rsrc_pkg::REG_SEG_COUNT, 15'd15);
        add_row(cast_beat(0, 0, 16'h0000), 0, 0, 0);
        add_row(cast_beat(0, 0, 16'h4000), 0, 0, 0);
        add_row(cast_beat(0, 0, 16'h8000), 0, 0, 0);
        add_row(cast_beat(0, 0, 16'hC000), 0, 0, 0);
        add_row(cast_beat(0, 0, 16'h2000), 0, 0, 0);
        add_row(cast_beat(0, 0, 16'hFFFF), 0, 0, 0);
        add_row(cast_beat(100, 1000, 16'h0001), 0, 0, 0);
        add_row(cast_beat(32767, -32768, 16'h7FFF), 0, 0, 0);
        run_rows();

        // An empty accept window returns the maximum range whatever is hit.
        write_reg(rsrc_pkg::REG_RANGE_MIN, 15'd4000);
        write_reg(rsrc_pkg::REG_RANGE_MAX, 15'd4000);
        add_row(cast_beat(0, 0, 16'h0000), 1, 4000, 0);
        run_rows();

        // Extreme window settings.
        write_reg(rsrc_pkg::REG_RANGE_MIN, 15'd0);
        write_reg(rsrc_pkg::REG_RANGE_MAX, 15'd32767);
        add_row(cast_beat(0, 0, 16'h4000), 0, 0, 0);
        add_row(cast_beat(-20000, 0, 16'h0000), 0, 0, 0);
        run_rows();
        write_reg(rsrc_pkg::REG_RANGE_MIN, 15'd32767);
        write_reg(rsrc_pkg::REG_RANGE_MAX, 15'd1);
        add_row(cast_beat(0, 0, 16'h0000), 1, 1, 0);
        run_rows();
        use_fixed = 1'b0;

        // Random part in four idling phases, each with its own register setting.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 46;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 46;
                end
                default:
                begin
                    send_idle_pct = 16;
                    recv_stall_pct = 16;
                end
            endcase
            write_reg(rsrc_pkg::REG_RANGE_MIN,
                      (phase == 0) ? 15'd0 : 15'($urandom_range(300)));
            write_reg(rsrc_pkg::REG_RANGE_MAX,
                      (phase == 3) ? 15'd32767 : 15'($urandom_range(32767, 3000)));
            write_reg(rsrc_pkg::REG_SEG_COUNT,
                      (phase == 0) ? 15'd8 : 15'($urandom_range(15)));
            for (int i = 0; i < 135; i++)
            begin
                if ($urandom_range(2) == 0)
                    b = wall_beat(3'($urandom), rand_coord(), rand_coord(),
                                  rand_coord(), rand_coord());
                else
                    b = cast_beat(rand_coord(), rand_coord(), 16'($urandom));
                send_beat(b);
                // Let everything drain once, partway through the phase.
                if (i == 60)
                begin
                    release_in();
                    do
                        @(posedge clk);
                    while (pending_ranges.size() != 0);
                end
            end
            drain();
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
